/* sv/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, sizes and codes for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int DATA_W      = 32;
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_PUSH = 3'd0,
		ACT_POP  = 3'd1,
		ACT_ADD  = 3'd2,
		ACT_SUB  = 3'd3,
		ACT_MUL  = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXEC
	} state_t;

	localparam logic [1:0] STATUS_OK    = 2'b00;
	localparam logic [1:0] STATUS_UNDER = 2'b01;
	localparam logic [1:0] STATUS_OVER  = 2'b10;

	function automatic logic [DATA_W-1:0] alu(
		input act_t              op,
		input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b
	);
		logic [DATA_W-1:0] prod;
		logic [DATA_W-1:0] res;
		prod = a * b;
		case (op)
			ACT_ADD: res = a + b;
			ACT_SUB: res = a - b;
			default: res = prod;
		endcase
		return res;
	endfunction

endpackage

/* sv/rsc_ram.sv */
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/rpn_stack_calculator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Postfix stack machine: push, pop, add, subtract (top minus next), multiply.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid, in_stall | action[2:0], push_value[31:0]
//  out     | out_valid, out_stall | out_value[31:0], depth_now[6:0], status[1:0]
//
//  Top of stack lives in a register; deeper entries live in a RAM with a
//  registered read. Push, no-op and ops on a stack of depth < 2 finish in
//  ST_IDLE; pop and arithmetic with depth >= 2 stall input in ST_LOAD or
//  ST_EXEC for the RAM read of the second entry. Reset empties the stack at once;
//  RAM contents are never cleared. A stalled output word holds off new input.
// ----------------------------------------------------------------------------
module rpn_stack_calculator
	import rsc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              action,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic [DEPTH_W-1:0]      depth_now,
	output logic [1:0]              status
);

	state_t              state_q, state_d;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic [DATA_W-1:0]   top_q, top_d;
	act_t                act_q, act_d;
	logic                out_valid_q, out_valid_d;
	logic [DATA_W-1:0]   out_value_q, out_value_d;
	logic [DEPTH_W-1:0]  out_depth_q, out_depth_d;
	logic [1:0]          out_status_q, out_status_d;

	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [DATA_W-1:0]   mem_rdata;

	logic                accept, out_free;
	act_t                act_in;
	logic [DEPTH_W-1:0]  depth_m1, depth_m2;
	act_t                alu_op;
	logic [DATA_W-1:0]   alu_a, alu_b, alu_r;

	localparam logic [DATA_W-1:0] NEG_ONE = '1;

	rsc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(top_q),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign act_in   = act_t'(action);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign depth_m2 = depth_q - DEPTH_W'(2);

	assign mem_waddr = depth_m1[ADDR_W-1:0];
	assign mem_raddr = depth_m2[ADDR_W-1:0];

	always_comb begin
		if (state_q == ST_EXEC) begin
			alu_op = act_q;
			alu_a  = top_q;
			alu_b  = mem_rdata;
		end else begin
			alu_op = act_in;
			alu_a  = (depth_q != '0) ? top_q : NEG_ONE;
			alu_b  = NEG_ONE;
		end
	end

	assign alu_r = alu(alu_op, alu_a, alu_b);

	always_comb begin
		state_d      = state_q;
		depth_d      = depth_q;
		top_d        = top_q;
		act_d        = act_q;
		out_valid_d  = out_valid_q && out_stall;
		out_value_d  = out_value_q;
		out_depth_d  = out_depth_q;
		out_status_d = out_status_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					act_d        = act_in;
					out_valid_d  = 1'b1;
					out_status_d = STATUS_OK;
					case (act_in)
						ACT_PUSH: begin
							if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
								out_value_d  = top_q;
								out_depth_d  = depth_q;
								out_status_d = STATUS_OVER;
							end else begin
								mem_we      = (depth_q != '0);
								top_d       = push_value;
								depth_d     = depth_q + DEPTH_W'(1);
								out_value_d = push_value;
								out_depth_d = depth_q + DEPTH_W'(1);
							end
						end
						ACT_POP: begin
							if (depth_q == '0) begin
								out_value_d  = NEG_ONE;
								out_depth_d  = depth_q;
								out_status_d = STATUS_UNDER;
							end else begin
								out_value_d = top_q;
								out_depth_d = depth_m1;
								depth_d     = depth_m1;
								if (depth_q >= DEPTH_W'(2)) begin
									mem_re  = 1'b1;
									state_d = ST_LOAD;
								end
							end
						end
						ACT_ADD, ACT_SUB, ACT_MUL: begin
							if (depth_q >= DEPTH_W'(2)) begin
								mem_re      = 1'b1;
								out_valid_d = 1'b0;
								state_d     = ST_EXEC;
							end else begin
								top_d        = alu_r;
								depth_d      = DEPTH_W'(1);
								out_value_d  = alu_r;
								out_depth_d  = DEPTH_W'(1);
								out_status_d = STATUS_UNDER;
							end
						end
						default: begin
							out_value_d = (depth_q != '0) ? top_q : '0;
							out_depth_d = depth_q;
						end
					endcase
				end
			end
			ST_LOAD: begin
				top_d   = mem_rdata;
				state_d = ST_IDLE;
			end
			ST_EXEC: begin
				top_d        = alu_r;
				depth_d      = depth_m1;
				out_valid_d  = 1'b1;
				out_value_d  = alu_r;
				out_depth_d  = depth_m1;
				out_status_d = STATUS_OK;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q        <= top_d;
		act_q        <= act_d;
		out_value_q  <= out_value_d;
		out_depth_q  <= out_depth_d;
		out_status_q <= out_status_d;
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign depth_now = out_depth_q;
	assign status    = out_status_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken while an operation is in flight");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> out_valid_q)
		else $error("arithmetic finished without an output word");

	a_pop_refill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act_in == ACT_POP && depth_q >= DEPTH_W'(2) |=> state_q == ST_LOAD)
		else $error("pop did not refill the top register");

endmodule
